// ----- rtl/sleep_package_extractor_top_defines.svh -----
// Assertion macros used by the sleep package extractor top level.
`ifndef SLEEP_PACKAGE_EXTRACTOR_TOP_DEFINES_SVH
`define SLEEP_PACKAGE_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define SPE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/spe_pkg.sv -----
// Types and constants of the sleep package extractor.
`default_nettype none
package spe_pkg;

	localparam int SLEEP_STATES = 6;
	localparam int STATE_W = 3;

	localparam logic [1:0] CMD_BYTE   = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [1:0] SEL_A = 2'd0;
	localparam logic [1:0] SEL_B = 2'd1;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_S          = 8'h53;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] BYTE_PREFIX   = 8'h0A;
	localparam logic [7:0] ABSENT        = 8'hFF;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_PKG_OP   = 4'd1,
		PH_LEAD     = 4'd2,
		PH_LEN_SKIP = 4'd3,
		PH_COUNT    = 4'd4,
		PH_A_FIRST  = 4'd5,
		PH_A_VALUE  = 4'd6,
		PH_B_FIRST  = 4'd7,
		PH_B_VALUE  = 4'd8
	} phase_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         table_byte;
		logic               last_byte;
		logic [1:0]         register_select;
		logic [7:0]         sleep_type_value;
		logic [STATE_W-1:0] state_index;
	} req_t;

	typedef struct packed {
		logic [STATE_W-1:0] found_state;
		logic [7:0]         entry_value;
	} res_t;

	// Table write strobes from one tracker; data is the current byte.
	typedef struct packed {
		logic we_a;
		logic we_b;
	} spe_wr_t;

endpackage
`default_nettype wire

// ----- rtl/spe_tracker.sv -----
// Per-state package tracker: walks one _Sn_ package and strobes its two entries.
`default_nettype none
module spe_tracker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic            restart,
	input  wire logic            last,
	input  wire logic            start,
	input  wire logic [7:0]      data,
	output spe_pkg::spe_wr_t     wr
);
	import spe_pkg::*;

	phase_t     phase_q, phase_cur, phase_adv, phase_d;
	logic [1:0] skip_q, skip_cur, skip_adv, skip_d;

	always_comb begin
		phase_cur = restart ? PH_IDLE : phase_q;
		skip_cur  = restart ? 2'd0 : skip_q;
		phase_adv = phase_cur;
		skip_adv  = skip_cur;
		wr        = '0;
		unique case (phase_cur)
			PH_PKG_OP: phase_adv = PH_LEAD;
			PH_LEAD: begin
				skip_adv  = data[7:6];
				phase_adv = (data[7:6] != 2'd0) ? PH_LEN_SKIP : PH_COUNT;
			end
			PH_LEN_SKIP: begin
				skip_adv = skip_cur - 2'd1;
				if (skip_cur == 2'd1) begin
					phase_adv = PH_COUNT;
				end
			end
			PH_COUNT: phase_adv = PH_A_FIRST;
			PH_A_FIRST: begin
				if (data == BYTE_PREFIX) begin
					phase_adv = PH_A_VALUE;
				end else begin
					wr.we_a   = step;
					phase_adv = PH_B_FIRST;
				end
			end
			PH_A_VALUE: begin
				wr.we_a   = step;
				phase_adv = PH_B_FIRST;
			end
			PH_B_FIRST: begin
				if (data == BYTE_PREFIX) begin
					phase_adv = PH_B_VALUE;
				end else begin
					wr.we_b   = step;
					phase_adv = PH_IDLE;
				end
			end
			PH_B_VALUE: begin
				wr.we_b   = step;
				phase_adv = PH_IDLE;
			end
			default: phase_adv = PH_IDLE;
		endcase

		phase_d = phase_adv;
		skip_d  = skip_adv;
		if (start) begin
			phase_d = PH_PKG_OP;
			skip_d  = 2'd0;
		end
		if (last) begin
			phase_d = PH_IDLE;
			skip_d  = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			skip_q  <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/spe_table.sv -----
// Sleep type table: A and B entries per state, clear on new table, lookup and read.
`default_nettype none
module spe_table (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        clear,
	input  wire logic [7:0]                                  data,
	input  wire spe_pkg::spe_wr_t [spe_pkg::SLEEP_STATES-1:0] wr,
	input  wire logic [1:0]                                  register_select,
	input  wire logic [7:0]                                  sleep_type_value,
	input  wire logic [spe_pkg::STATE_W-1:0]                 state_index,
	output logic [spe_pkg::STATE_W-1:0]                      found_state,
	output logic [7:0]                                       entry_value
);
	import spe_pkg::*;

	logic [7:0] tbl_a_q [SLEEP_STATES];
	logic [7:0] tbl_b_q [SLEEP_STATES];
	logic [7:0] tbl_a_d [SLEEP_STATES];
	logic [7:0] tbl_b_d [SLEEP_STATES];

	always_comb begin
		for (int n = 0; n < SLEEP_STATES; n++) begin
			tbl_a_d[n] = clear ? ABSENT : tbl_a_q[n];
			tbl_b_d[n] = clear ? ABSENT : tbl_b_q[n];
			if (wr[n].we_a) begin
				tbl_a_d[n] = data;
			end
			if (wr[n].we_b) begin
				tbl_b_d[n] = data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < SLEEP_STATES; n++) begin
				tbl_a_q[n] <= ABSENT;
				tbl_b_q[n] <= ABSENT;
			end
		end else begin
			for (int n = 0; n < SLEEP_STATES; n++) begin
				tbl_a_q[n] <= tbl_a_d[n];
				tbl_b_q[n] <= tbl_b_d[n];
			end
		end
	end

	// lowest matching state wins: scan downward, last hit stays
	always_comb begin
		found_state = '0;
		entry_value = ABSENT;
		for (int n = SLEEP_STATES - 1; n >= 0; n--) begin
			if ((register_select == SEL_A && tbl_a_q[n] == sleep_type_value) ||
			    (register_select == SEL_B && tbl_b_q[n] == sleep_type_value)) begin
				found_state = STATE_W'(n);
			end
		end
		for (int n = 0; n < SLEEP_STATES; n++) begin
			if (state_index == STATE_W'(n)) begin
				if (register_select == SEL_A) begin
					entry_value = tbl_a_q[n];
				end else if (register_select == SEL_B) begin
					entry_value = tbl_b_q[n];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sleep_package_extractor_top.sv -----
// Top level of the sleep package extractor: request register, name matcher, result register.
//
// Requests stream in one per cycle: DSDT body bytes (command 0) build a table
// of SLP_TYP values for control blocks A and B of each sleep state, and lookup
// (command 1) or read (command 2) requests return one result each; command 3
// is dropped. A request is taken into a request register, worked there by the
// name matcher, six package trackers and the table, and a result lands in the
// result register. Sustained rate is one request per cycle; only a result
// register that is held by res_stall while a new lookup or read waits stops
// intake. Byte requests flow on past a stalled result. The first byte after
// reset or after a byte marked last resets the table to 0xFF in that same
// cycle, so no clearing pass is needed.
`default_nettype none
`include "sleep_package_extractor_top_defines.svh"
module sleep_package_extractor_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire spe_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_stall,
	output spe_pkg::res_t      res
);
	import spe_pkg::*;

	// request register
	logic  valid_s1;
	req_t  req_s1;

	// scan state
	logic [23:0]             hist_q;
	logic [SLEEP_STATES-1:0] found_q;
	logic                    pending_q;

	// result register
	logic  res_valid_q;
	res_t  res_q;

	logic                    needs_res, adv, accept, byte_step, restart;
	logic [23:0]             hist_cur;
	logic [SLEEP_STATES-1:0] found_cur, start;
	spe_wr_t [SLEEP_STATES-1:0] wr;
	logic [STATE_W-1:0]      lookup_state;
	logic [7:0]              read_value;

	assign needs_res = valid_s1 && (req_s1.command == CMD_LOOKUP ||
	                                req_s1.command == CMD_READ);
	// a request with a result moves on only when the result slot frees
	assign adv       = valid_s1 && (!needs_res || !res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;
	assign byte_step = adv && req_s1.command == CMD_BYTE;
	assign restart   = byte_step && pending_q;

	// name match: history holds the three bytes before the current one
	always_comb begin
		hist_cur  = restart ? 24'd0 : hist_q;
		found_cur = restart ? '0 : found_q;
		for (int n = 0; n < SLEEP_STATES; n++) begin
			start[n] = byte_step && !found_cur[n] &&
			           hist_cur == {CH_UNDERSCORE, CH_S, 8'(CH_ZERO + 8'(n))} &&
			           req_s1.table_byte == CH_UNDERSCORE;
		end
	end

	for (genvar g = 0; g < SLEEP_STATES; g++) begin : g_trk
		spe_tracker u_trk (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (byte_step),
			.restart (restart),
			.last    (req_s1.last_byte),
			.start   (start[g]),
			.data    (req_s1.table_byte),
			.wr      (wr[g])
		);
	end

	spe_table u_tbl (
		.clk              (clk),
		.arst_n           (arst_n),
		.clear            (restart),
		.data             (req_s1.table_byte),
		.wr               (wr),
		.register_select  (req_s1.register_select),
		.sleep_type_value (req_s1.sleep_type_value),
		.state_index      (req_s1.state_index),
		.found_state      (lookup_state),
		.entry_value      (read_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= 24'd0;
			found_q   <= '0;
			pending_q <= 1'b1;
		end else if (byte_step) begin
			hist_q    <= {hist_cur[15:0], req_s1.table_byte};
			found_q   <= found_cur | start;
			pending_q <= req_s1.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && needs_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && needs_res) begin
			if (req_s1.command == CMD_LOOKUP) begin
				res_q.found_state <= lookup_state;
				res_q.entry_value <= 8'd0;
			end else begin
				res_q.found_state <= '0;
				res_q.entry_value <= read_value;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SPE_ASSERT(a_last_sets_pending, clk, arst_n, (byte_step && req_s1.last_byte) |=> pending_q, "last byte did not arm table restart")
	`SPE_ASSERT(a_found_grows, clk, arst_n, !restart |=> ((found_q & $past(found_q)) == $past(found_q)), "found bit dropped without a table restart")
	`SPE_ASSERT(a_result_held, clk, arst_n, (res_valid_q && res_stall) |=> (res_valid_q && $stable(res_q)), "held result overwritten")

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the sleep package extractor top level.
module tb;
	import spe_pkg::*;

	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam logic [7:0] PKG_OP      = 8'h12;
	localparam int RANDOM_ITEMS = 550;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 21;
	// No idling on either side while the count of taken requests lies in this range.
	localparam int CALM_FROM = 120;
	localparam int CALM_TO   = 260;
	// Long receiver hold-off, so a waiting lookup or read backs up the input.
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	sleep_package_extractor_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Predicted scanner state.
	logic [23:0]             recent_bytes;
	logic [7:0]              slp_typ [2*SLEEP_STATES];
	logic [SLEEP_STATES-1:0] name_seen;
	phase_t                  pkg_phase [SLEEP_STATES];
	logic [1:0]              len_left [SLEEP_STATES];
	logic                    table_fresh;

	req_t       pending_reqs[$];
	res_t       due_results[$];
	logic [7:0] planted[$];
	res_t       oldest_due;

	int   queued_items = 0;
	int   total_reqs = 0;
	int   accepted_cnt = 0;
	int   errors = 0;
	int   cycles = 0;
	int   hold_left = 0;
	bit   hold_done = 0;
	logic calm;

	assign calm = accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
		errors++;
	endtask

	task automatic clear_table();
		recent_bytes = '0;
		name_seen = '0;
		foreach (slp_typ[i]) slp_typ[i] = ABSENT;
		for (int n = 0; n < SLEEP_STATES; n++) begin
			pkg_phase[n] = PH_IDLE;
			len_left[n] = '0;
		end
	endtask

	// Applies one accepted request to the predicted state; queues its result.
	task automatic sleep_table_step(req_t r);
		logic [7:0] b;
		res_t out;
		logic hit;
		int base;
		b = r.table_byte;
		out = '0;
		hit = 1'b0;
		base = (r.register_select == SEL_B) ? SLEEP_STATES : 0;
		if (r.command == CMD_BYTE) begin
			if (table_fresh) begin
				clear_table();
				table_fresh = 1'b0;
			end
			for (int n = 0; n < SLEEP_STATES; n++) begin
				case (pkg_phase[n])
					PH_PKG_OP: pkg_phase[n] = PH_LEAD;
					PH_LEAD: begin
						len_left[n] = b[7:6];
						pkg_phase[n] = (b[7:6] != 2'd0) ? PH_LEN_SKIP : PH_COUNT;
					end
					PH_LEN_SKIP: begin
						len_left[n] = len_left[n] - 2'd1;
						if (len_left[n] == 2'd0)
							pkg_phase[n] = PH_COUNT;
					end
					PH_COUNT: pkg_phase[n] = PH_A_FIRST;
					PH_A_FIRST: begin
						if (b == BYTE_PREFIX) begin
							pkg_phase[n] = PH_A_VALUE;
						end else begin
							slp_typ[n] = b;
							pkg_phase[n] = PH_B_FIRST;
						end
					end
					PH_A_VALUE: begin
						slp_typ[n] = b;
						pkg_phase[n] = PH_B_FIRST;
					end
					PH_B_FIRST: begin
						if (b == BYTE_PREFIX) begin
							pkg_phase[n] = PH_B_VALUE;
						end else begin
							slp_typ[SLEEP_STATES + n] = b;
							pkg_phase[n] = PH_IDLE;
						end
					end
					PH_B_VALUE: begin
						slp_typ[SLEEP_STATES + n] = b;
						pkg_phase[n] = PH_IDLE;
					end
					default: pkg_phase[n] = PH_IDLE;
				endcase
				// only the first "_Sn_" of a table opens a package
				if (!name_seen[n] && b == CH_UNDERSCORE &&
						recent_bytes == {CH_UNDERSCORE, CH_S, CH_ZERO + 8'(n)}) begin
					name_seen[n] = 1'b1;
					pkg_phase[n] = PH_PKG_OP;
					len_left[n] = '0;
				end
			end
			recent_bytes = {recent_bytes[15:0], b};
			if (r.last_byte) begin
				// open packages are dropped, entries kept
				for (int n = 0; n < SLEEP_STATES; n++) begin
					pkg_phase[n] = PH_IDLE;
					len_left[n] = '0;
				end
				table_fresh = 1'b1;
			end
		end else if (r.command == CMD_LOOKUP) begin
			if (r.register_select == SEL_A || r.register_select == SEL_B) begin
				for (int n = 0; n < SLEEP_STATES; n++) begin
					if (!hit && slp_typ[base + n] == r.sleep_type_value) begin
						out.found_state = STATE_W'(n);
						hit = 1'b1;
					end
				end
			end
			due_results.push_back(out);
		end else if (r.command == CMD_READ) begin
			out.entry_value = ABSENT;
			if ((r.register_select == SEL_A || r.register_select == SEL_B) &&
					r.state_index < SLEEP_STATES)
				out.entry_value = slp_typ[base + int'(r.state_index)];
			due_results.push_back(out);
		end
	endtask

	function automatic req_t random_req();
		logic [31:0] rnd;
		rnd = $urandom;
		return rnd[$bits(req_t)-1:0];
	endfunction

	task automatic queue_req(req_t r);
		pending_reqs.push_back(r);
		if (r.command != CMD_IGNORED)
			queued_items++;
	endtask

	task automatic push_byte(logic [7:0] b, logic last);
		req_t r;
		r = random_req();
		r.command = CMD_BYTE;
		r.table_byte = b;
		r.last_byte = last;
		queue_req(r);
	endtask

	task automatic push_query(logic [1:0] cmd, logic [1:0] sel, logic [7:0] val,
			logic [STATE_W-1:0] idx);
		req_t r;
		r = random_req();
		r.command = cmd;
		r.register_select = sel;
		r.sleep_type_value = val;
		r.state_index = idx;
		queue_req(r);
	endtask

	function automatic logic [7:0] type_value();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 2))
					0: return 8'h00;
					1: return ABSENT;
					default: return BYTE_PREFIX;
				endcase
			end
			default: return 8'($urandom);
		endcase
	endfunction

	// Filler biased toward name characters so names also land inside packages.
	function automatic logic [7:0] stray_byte();
		case ($urandom_range(0, 4))
			0: return CH_UNDERSCORE;
			1: return CH_S;
			2: return CH_ZERO + 8'($urandom_range(0, 6));
			3: return BYTE_PREFIX;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_query();
		logic [1:0] sel;
		logic [7:0] val;
		sel = ($urandom_range(99) < 85) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
		if (planted.size() != 0 && $urandom_range(99) < 60)
			val = planted[$urandom_range(0, planted.size() - 1)];
		else
			val = type_value();
		push_query($urandom_range(0, 1) ? CMD_LOOKUP : CMD_READ, sel, val,
			STATE_W'($urandom_range(0, 7)));
	endtask

	// One table body: a few packages among filler, sometimes cut short or left
	// open, then a handful of lookups and reads.
	task automatic add_table();
		logic [7:0] body[$];
		logic [7:0] lead;
		logic [7:0] v;
		logic close;
		int len;
		for (int k = $urandom_range(1, 4); k > 0; k--) begin
			repeat ($urandom_range(0, 3)) body.push_back(stray_byte());
			body.push_back(CH_UNDERSCORE);
			body.push_back(CH_S);
			body.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			body.push_back(CH_UNDERSCORE);
			body.push_back(($urandom_range(9) == 0) ? stray_byte() : PKG_OP);
			lead = 8'($urandom);
			body.push_back(lead);
			repeat (lead[7:6]) body.push_back(stray_byte());
			body.push_back(stray_byte());
			repeat (2) begin
				v = type_value();
				if ($urandom_range(0, 1))
					body.push_back(BYTE_PREFIX);
				body.push_back(v);
				planted.push_back(v);
			end
		end
		if ($urandom_range(99) < 20) begin
			len = $urandom_range(1, body.size());
			repeat (body.size() - len) void'(body.pop_back());
		end
		close = $urandom_range(99) < 85;
		foreach (body[i])
			push_byte(body[i], close && i == body.size() - 1);
		repeat ($urandom_range(2, 6)) add_query();
		while (planted.size() > 16) void'(planted.pop_front());
	endtask

	// Driver: once the current request is taken, offers the next one or idles at random outside the calm window.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				sleep_table_step(req);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result, entry_value", res.entry_value, 0);
			end else begin
				oldest_due = due_results.pop_front();
				if (res.found_state !== oldest_due.found_state)
					report_mismatch("found_state", res.found_state, oldest_due.found_state);
				if (res.entry_value !== oldest_due.entry_value)
					report_mismatch("entry_value", res.entry_value, oldest_due.entry_value);
			end
		end
	end

	always @(posedge clk) begin
		if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			res_stall <= hold_left != 0 || (!calm && $urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] demo_pkg [15];
		int target;
		req_t r;
		clear_table();
		table_fresh = 1'b1;

		// Empty table: every entry absent, invalid selects and indexes.
		push_query(CMD_READ, SEL_A, 8'h00, 3'd0);
		push_query(CMD_LOOKUP, SEL_B, ABSENT, 3'd0);
		push_query(CMD_READ, 2'd3, 8'hFF, 3'd7);
		push_query(CMD_READ, SEL_A, 8'h00, 3'd6);
		// "_S5_" with three length bytes and both values behind a prefix.
		demo_pkg = '{CH_UNDERSCORE, CH_S, CH_ZERO + 8'd5, CH_UNDERSCORE, PKG_OP, 8'hC0,
			8'h01, 8'h02, 8'h03, 8'h02, BYTE_PREFIX, 8'h00, BYTE_PREFIX, BYTE_PREFIX, 8'hFF};
		foreach (demo_pkg[i])
			push_byte(demo_pkg[i], i == 14);
		push_query(CMD_READ, SEL_A, 8'h00, 3'd5);
		push_query(CMD_READ, SEL_B, 8'h00, 3'd5);
		push_query(CMD_LOOKUP, SEL_A, 8'h00, 3'd0);
		push_query(CMD_LOOKUP, 2'd2, 8'h00, 3'd0);
		r = random_req();
		r.command = CMD_IGNORED;
		queue_req(r);

		target = queued_items + RANDOM_ITEMS;
		while (queued_items < target) begin
			if ($urandom_range(99) < 85) begin
				add_table();
			end else begin
				r = random_req();
				case ($urandom_range(0, 2))
					0: begin
						r.command = CMD_IGNORED;
						queue_req(r);
					end
					1: begin
						r.command = CMD_BYTE;
						queue_req(r);
					end
					default: add_query();
				endcase
			end
		end
		total_reqs = pending_reqs.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt != total_reqs) @(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		// wait on to catch any stray result
		repeat (10) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sleep_package_extractor_top.f -----
+incdir+rtl
rtl/spe_pkg.sv
rtl/spe_tracker.sv
rtl/spe_table.sv
rtl/sleep_package_extractor_top.sv
dv/tb.sv
